// ===== rtl/core/indexed_shift_list_store_unit_assert.svh =====
// Assertion macros shared by the list store RTL.
`ifndef INDEXED_SHIFT_LIST_STORE_UNIT_ASSERT_SVH
`define INDEXED_SHIFT_LIST_STORE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ISLSU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define ISLSU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/islsu_pkg.sv =====
package islsu_pkg;

   localparam int CAPACITY = 64;
   localparam int INDEX_W  = $clog2(CAPACITY);
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int FUNC_W   = 3;
   localparam int STATUS_W = 2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_APPEND   = 3'd0,
      FUNC_INSERT   = 3'd1,
      FUNC_REMOVE   = 3'd2,
      FUNC_POP_AT   = 3'd3,
      FUNC_POP_LAST = 3'd4,
      FUNC_READ     = 3'd5,
      FUNC_WRITE    = 3'd6,
      FUNC_NOP      = 3'd7
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_EMPTY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD       = 2'd0,
      CELL_WRITE      = 2'd1,
      CELL_SHIFT_UP   = 2'd2,
      CELL_SHIFT_DOWN = 2'd3
   } cell_op_type;

   // Broadcast to every cell of the chain.
   typedef struct packed {
      cell_op_type               op;
      logic [INDEX_W-1:0]        pos;
      logic signed [DATA_W-1:0]  value;
      logic                      read_en;
      logic [INDEX_W-1:0]        read_pos;
   } cell_cmd_type;

   // Result of one request apart from the word read.
   typedef struct packed {
      status_type                status;
      logic [COUNT_W-1:0]        entry_count;
   } rsp_info_type;

endpackage

// ===== rtl/core/islsu_chan_if.sv =====
interface islsu_req_if import islsu_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [FUNC_W-1:0]         func;
   logic [INDEX_W-1:0]        position;
   logic signed [DATA_W-1:0]  item_value;

   modport source (output valid, output func, output position, output item_value,
                   input ready);
   modport sink   (input valid, input func, input position, input item_value,
                   output ready);
endinterface

interface islsu_rsp_if import islsu_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [DATA_W-1:0]  read_value;
   logic [STATUS_W-1:0]       status;
   logic [COUNT_W-1:0]        entry_count;

   modport source (output valid, output read_value, output status, output entry_count,
                   input ready);
   modport sink   (input valid, input read_value, input status, input entry_count,
                   output ready);
endinterface

// ===== rtl/core/islsu_cell.sv =====
module islsu_cell import islsu_pkg::*; (
   input  logic                      clock,
   input  logic [INDEX_W-1:0]        cell_index,
   input  cell_cmd_type              cmd,
   input  logic signed [DATA_W-1:0]  lower_data,
   input  logic signed [DATA_W-1:0]  upper_data,
   output logic signed [DATA_W-1:0]  data_out,
   output logic signed [DATA_W-1:0]  tap_out
);

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (cmd.op)
         CELL_WRITE: begin
            if (cell_index == cmd.pos) data_in = cmd.value;
         end
         CELL_SHIFT_UP: begin
            // make room at pos: take the new word there, the lower neighbour above it
            if (cell_index == cmd.pos)     data_in = cmd.value;
            else if (cell_index > cmd.pos) data_in = lower_data;
         end
         CELL_SHIFT_DOWN: begin
            if (cell_index >= cmd.pos) data_in = upper_data;
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;
   assign tap_out  = (cmd.read_en && (cell_index == cmd.read_pos)) ? data_ff : '0;

endmodule

// ===== rtl/core/islsu_ctrl.sv =====
module islsu_ctrl import islsu_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [FUNC_W-1:0]         func,
   input  logic [INDEX_W-1:0]        position,
   input  logic signed [DATA_W-1:0]  item_value,
   output cell_cmd_type              cmd,
   output rsp_info_type              info,
   output logic [COUNT_W-1:0]        count_out
);

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [COUNT_W-1:0] pos_ext;
   logic [COUNT_W-1:0] count_inc;
   logic [COUNT_W-1:0] count_dec;
   logic               is_full;
   logic               is_empty;
   logic               pos_ge_count;
   status_type         status;
   logic [COUNT_W-1:0] count_after;

   assign pos_ext      = COUNT_W'(position);
   assign count_inc    = count_ff + COUNT_W'(1);
   assign count_dec    = count_ff - COUNT_W'(1);
   assign is_full      = (count_ff >= COUNT_W'(CAPACITY));
   assign is_empty     = (count_ff == '0);
   assign pos_ge_count = (pos_ext >= count_ff);

   // Decode the request into a status, the new count and a cell command.
   always_comb begin
      status       = STATUS_OK;
      count_after  = count_ff;
      cmd.op       = CELL_HOLD;
      cmd.pos      = position;
      cmd.value    = item_value;
      cmd.read_en  = 1'b0;
      cmd.read_pos = position;
      case (func_type'(func))
         FUNC_APPEND: begin
            if (is_full) begin
               status = STATUS_FULL;
            end else begin
               cmd.op      = CELL_WRITE;
               cmd.pos     = count_ff[INDEX_W-1:0];
               count_after = count_inc;
            end
         end
         FUNC_INSERT: begin
            if (pos_ext > count_ff) begin
               status = STATUS_RANGE;
            end else if (is_full) begin
               status = STATUS_FULL;
            end else begin
               cmd.op      = CELL_SHIFT_UP;
               count_after = count_inc;
            end
         end
         FUNC_REMOVE, FUNC_POP_AT: begin
            if (is_empty) begin
               status = STATUS_EMPTY;
            end else if (pos_ge_count) begin
               status = STATUS_RANGE;
            end else begin
               cmd.op      = CELL_SHIFT_DOWN;
               cmd.read_en = (func_type'(func) == FUNC_POP_AT);
               count_after = count_dec;
            end
         end
         FUNC_POP_LAST: begin
            if (is_empty) begin
               status = STATUS_EMPTY;
            end else begin
               // entries at or above the count are dead, so no shift is needed
               cmd.read_en  = 1'b1;
               cmd.read_pos = count_dec[INDEX_W-1:0];
               count_after  = count_dec;
            end
         end
         FUNC_READ: begin
            if (pos_ge_count) status = STATUS_RANGE;
            else              cmd.read_en = 1'b1;
         end
         FUNC_WRITE: begin
            if (pos_ge_count) status = STATUS_RANGE;
            else              cmd.op = CELL_WRITE;
         end
         default: status = STATUS_OK;
      endcase
      if (!accept) begin
         cmd.op      = CELL_HOLD;
         cmd.read_en = 1'b0;
      end
   end

   always_comb begin
      count_in = accept ? count_after : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign info.status      = status;
   assign info.entry_count = count_after;
   assign count_out        = count_ff;

endmodule

// ===== rtl/core/indexed_shift_list_store_unit.sv =====
// Indexed shift list store: an ordered list of up to CAPACITY signed 32-bit
// words with a running count, held in a chain of identical cells.
// req_chan (valid/ready) carries one request: func picks append, insert,
// remove, pop at index, pop last, read or write; position and item_value
// give the index and the word. rsp_chan returns one item per request with
// the word read or popped (zero otherwise), a status (ok, index out of
// range, full, empty) and the count after the request.
// rsp_chan.valid rises in the cycle after acceptance; one request is
// taken per cycle while rsp_chan is not stalled. Every cell takes its own
// word, the new word or a neighbour's in the cycle the request is taken,
// and the count register updates in that same cycle.
// Reset clears the count and the response valid; cell contents stay as
// they were and are never read before being written.
// A stalled rsp_chan holds its item; a new request is taken only while the
// response register is empty or being drained in the same cycle.
module indexed_shift_list_store_unit import islsu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   islsu_req_if.sink    req_chan,
   islsu_rsp_if.source  rsp_chan
);

`include "indexed_shift_list_store_unit_assert.svh"

   logic                      accept;
   cell_cmd_type              cmd;
   rsp_info_type              info;
   logic [COUNT_W-1:0]        count;
   logic signed [DATA_W-1:0]  cell_data [CAPACITY];
   logic signed [DATA_W-1:0]  cell_tap  [CAPACITY];
   logic signed [DATA_W-1:0]  read_word;

   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic signed [DATA_W-1:0]  rsp_value_ff;
   logic signed [DATA_W-1:0]  rsp_value_in;
   rsp_info_type              rsp_info_ff;
   rsp_info_type              rsp_info_in;

   // Take a request while the response register is free or draining.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   islsu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .func       (req_chan.func),
      .position   (req_chan.position),
      .item_value (req_chan.item_value),
      .cmd        (cmd),
      .info       (info),
      .count_out  (count)
   );

   // Cell chain: each sees its neighbours, cell 0 the new word as lower.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [DATA_W-1:0] lower;
      logic signed [DATA_W-1:0] upper;

      if (g == 0) begin : g_first
         assign lower = cmd.value;
      end else begin : g_lower
         assign lower = cell_data[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign upper = cell_data[g];
      end else begin : g_upper
         assign upper = cell_data[g+1];
      end

      islsu_cell u_cell (
         .clock      (clock),
         .cell_index (INDEX_W'(g)),
         .cmd        (cmd),
         .lower_data (lower),
         .upper_data (upper),
         .data_out   (cell_data[g]),
         .tap_out    (cell_tap[g])
      );
   end

   // At most one cell drives a non-zero tap, so OR the taps together.
   always_comb begin
      read_word = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_word = read_word | cell_tap[i];
      end
   end

   // Response register: load on accept, drop once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_info_in  = rsp_info_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = read_word;
         rsp_info_in  = info;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_info_ff  <= rsp_info_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.read_value  = rsp_value_ff;
   assign rsp_chan.status      = rsp_info_ff.status;
   assign rsp_chan.entry_count = rsp_info_ff.entry_count;

   `ISLSU_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count <= COUNT_W'(CAPACITY), "count above capacity")
   `ISLSU_ASSERT_NOW(a_rsp_count_tracks, clock, reset, rsp_valid_ff, rsp_info_ff.entry_count == count, "response count differs from list count")
   `ISLSU_ASSERT_NEXT(a_error_keeps_count, clock, reset, accept && (info.status != STATUS_OK), count == $past(count), "failed request changed the count")
   `ISLSU_ASSERT_NOW(a_error_zero_value, clock, reset, rsp_valid_ff && (rsp_info_ff.status != STATUS_OK), rsp_value_ff == '0, "failed request returned a value")

endmodule
